// ===== design/lrfe_pkg.sv =====
`default_nettype none

package lrfe_pkg;

    localparam int TABLE_REGS      = 4;
    localparam int ENTRY_W         = 14;
    localparam int TMO_W           = 16;
    localparam int FUNC_W          = 2;
    localparam int BYTE_W          = 8;
    localparam int SLOT_W          = 3;
    localparam int KIND_W          = 3;
    localparam int IDX_W           = 2;
    localparam int POS_W           = 4;
    localparam int SUM_W           = 12;
    localparam int REG_IDX_W       = 3;
    localparam int PADDR_W         = REG_IDX_W + 2;
    localparam int PDATA_W         = 32;

    localparam int DEF_NUM_ENTRIES = 4;
    localparam int DEF_MAX_DATA    = 8;

    localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;

    localparam int ENT_LEN_LSB = 8;
    localparam int ENT_RX_BIT  = 12;
    localparam int ENT_VLD_BIT = 13;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_HDR  = 2'd0,
        FUNC_BYTE = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_TXWR = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_TX      = 3'd0,
        KIND_RX      = 3'd1,
        KIND_RX_GOOD = 3'd2,
        KIND_RX_BAD  = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_TIMEOUT = 3'd5
    } t_kind;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENTRY0  = 3'd0,
        REG_ENTRY1  = 3'd1,
        REG_ENTRY2  = 3'd2,
        REG_ENTRY3  = 3'd3,
        REG_TIMEOUT = 3'd4
    } t_reg;

    typedef struct packed {
        logic [TABLE_REGS-1:0][ENTRY_W-1:0] entry;
        logic [TMO_W-1:0]                   timeout;
    } t_cfg;

    typedef struct packed {
        logic              rd;
        logic [SLOT_W-1:0] raddr;
        logic              wr;
        logic [SLOT_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
    } t_txm_req;

    // enhanced checksum: fold carries into the low byte twice, then invert
    function automatic logic [BYTE_W-1:0] fold_checksum(input logic [SUM_W-1:0] s);
        logic [BYTE_W:0] s1;
        logic [BYTE_W:0] s2;
        s1 = {1'b0, s[BYTE_W-1:0]} + (BYTE_W+1)'(s[SUM_W-1:BYTE_W]);
        s2 = {1'b0, s1[BYTE_W-1:0]} + (BYTE_W+1)'(s1[BYTE_W]);
        return ~s2[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/lrfe_if.sv =====
`default_nettype none

interface lrfe_in_if;
    import lrfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] value;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, func, value, slot, input ready);
    modport sink   (input valid, func, value, slot, output ready);
endinterface

interface lrfe_out_if;
    import lrfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  entry_index;
    logic [POS_W-1:0]  byte_position;
    logic              last;

    modport source (output valid, kind, data, entry_index, byte_position, last, input ready);
    modport sink   (input valid, kind, data, entry_index, byte_position, last, output ready);
endinterface

`default_nettype wire

// ===== design/lrfe_cfg.sv =====
`default_nettype none

module lrfe_cfg #(
    parameter int NUM_ENTRIES = lrfe_pkg::DEF_NUM_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrfe_pkg::PADDR_W-1:0] paddr,
    input  logic [lrfe_pkg::PDATA_W-1:0] pwdata,
    output logic [lrfe_pkg::PDATA_W-1:0] prdata,
    output lrfe_pkg::t_cfg               o_cfg
);
    import lrfe_pkg::*;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [TMO_W-1:0]     r_timeout;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // entries past NUM_ENTRIES never match, so they are not stored
    for (genvar gi = 0; gi < TABLE_REGS; gi++) begin : g_entry
        if (gi < NUM_ENTRIES) begin : g_reg
            logic [ENTRY_W-1:0] r_ent;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ent <= '0;
                end else if (wr_en && reg_idx == REG_IDX_W'(gi)) begin
                    r_ent <= pwdata[ENTRY_W-1:0];
                end
            end
            assign o_cfg.entry[gi] = r_ent;
        end else begin : g_none
            assign o_cfg.entry[gi] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TMO_RESET;
        end else if (wr_en && reg_idx == REG_TIMEOUT) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

    assign o_cfg.timeout = r_timeout;

    always_comb begin
        case (reg_idx)
            REG_ENTRY0, REG_ENTRY1, REG_ENTRY2, REG_ENTRY3: begin
                prdata = PDATA_W'(o_cfg.entry[reg_idx[IDX_W-1:0]]);
            end
            REG_TIMEOUT: begin
                prdata = PDATA_W'(r_timeout);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lrfe_txmem.sv =====
`default_nettype none

module lrfe_txmem #(
    parameter int MAX_DATA = lrfe_pkg::DEF_MAX_DATA
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrfe_pkg::t_txm_req          i_req,
    output logic [lrfe_pkg::BYTE_W-1:0] o_rdata
);
    import lrfe_pkg::*;

    localparam int TX_AW    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int TX_DEPTH = 1 << TX_AW;

    logic [BYTE_W-1:0]   r_mem [TX_DEPTH];
    logic [TX_DEPTH-1:0] r_vld;
    logic [BYTE_W-1:0]   r_rdata;
    logic                wr_hit;
    logic [TX_AW-1:0]    waddr;
    logic [TX_AW-1:0]    raddr;

    assign wr_hit = i_req.wr && (SLOT_W'(i_req.waddr) < SLOT_W'(TX_DEPTH - 1) ||
                                 SLOT_W'(i_req.waddr) == SLOT_W'(TX_DEPTH - 1));
    assign waddr  = i_req.waddr[TX_AW-1:0];
    assign raddr  = i_req.raddr[TX_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[waddr] <= i_req.wdata;
        end
    end

    // unwritten slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_hit) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_vld[raddr] ? r_mem[raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/lrfe_ctrl.sv =====
`default_nettype none

module lrfe_ctrl #(
    parameter int NUM_ENTRIES = lrfe_pkg::DEF_NUM_ENTRIES,
    parameter int MAX_DATA    = lrfe_pkg::DEF_MAX_DATA
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrfe_pkg::t_cfg              i_cfg,
    lrfe_in_if.sink                     i_item,
    lrfe_out_if.source                  o_res,
    output lrfe_pkg::t_txm_req          o_txm,
    input  logic [lrfe_pkg::BYTE_W-1:0] i_txm_rdata
);
    import lrfe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TX   = 2'b10
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_res;

    localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_DATA);

    function automatic logic [POS_W-1:0] entry_len(input logic [ENTRY_W-1:0] e);
        logic [POS_W-1:0] n;
        n = e[ENT_LEN_LSB +: POS_W];
        return (n > MAX_LEN) ? MAX_LEN : n;
    endfunction

    t_state           r_state,     n_state;
    logic             r_rx_open,   n_rx_open;
    logic [IDX_W-1:0] r_cur,       n_cur;
    logic [POS_W-1:0] r_cnt,       n_cnt;
    logic [SUM_W-1:0] r_sum,       n_sum;
    logic [TMO_W-1:0] r_tmo,       n_tmo;
    logic [POS_W-1:0] r_len,       n_len;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic [SUM_W-1:0] r_tsum,      n_tsum;
    logic             r_out_valid, n_out_valid;
    t_res             r_out,       n_out;

    logic               out_free;
    logic               acc;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [ENTRY_W-1:0] hit_e;
    logic [ENTRY_W-1:0] cur_e;
    logic [POS_W-1:0]   cur_len;
    logic [POS_W-1:0]   pos_nx;

    assign out_free     = !r_out_valid || o_res.ready;
    assign i_item.ready = (r_state == ST_IDLE) && out_free;
    assign acc          = i_item.valid && i_item.ready;

    // lowest valid matching entry wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_REGS - 1; i >= 0; i--) begin
            if (i < NUM_ENTRIES && i_cfg.entry[i][ENT_VLD_BIT] &&
                i_cfg.entry[i][BYTE_W-1:0] == i_item.value) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_e   = i_cfg.entry[hit_idx];
    assign cur_e   = i_cfg.entry[r_cur];
    assign cur_len = entry_len(cur_e);
    assign pos_nx  = r_pos + POS_W'(1);

    always_comb begin
        n_state     = r_state;
        n_rx_open   = r_rx_open;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_tmo       = r_tmo;
        n_len       = r_len;
        n_pos       = r_pos;
        n_tsum      = r_tsum;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        o_txm       = '0;

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_item.func)
                        FUNC_HDR: begin
                            n_rx_open = 1'b0;
                            n_cnt     = '0;
                            n_sum     = '0;
                            n_tmo     = '0;
                            if (!hit) begin
                                n_out_valid = 1'b1;
                                n_out       = '{KIND_UNKNOWN, '0, '0, '0, 1'b1};
                            end else begin
                                n_cur = hit_idx;
                                if (hit_e[ENT_RX_BIT]) begin
                                    n_rx_open = 1'b1;
                                    n_tmo     = i_cfg.timeout;
                                end else begin
                                    n_state     = ST_TX;
                                    n_len       = entry_len(hit_e);
                                    n_pos       = '0;
                                    n_tsum      = SUM_W'(i_item.value);
                                    o_txm.rd    = (entry_len(hit_e) != '0);
                                    o_txm.raddr = '0;
                                end
                            end
                        end
                        FUNC_BYTE: begin
                            if (r_rx_open) begin
                                n_out_valid = 1'b1;
                                if (r_cnt < cur_len) begin
                                    n_out = '{KIND_RX, i_item.value, r_cur, r_cnt, 1'b1};
                                    n_sum = r_sum + SUM_W'(i_item.value);
                                    n_cnt = r_cnt + POS_W'(1);
                                    n_tmo = i_cfg.timeout;
                                end else begin
                                    if (fold_checksum(r_sum + SUM_W'(cur_e[BYTE_W-1:0])) ==
                                        i_item.value) begin
                                        n_out = '{KIND_RX_GOOD, '0, r_cur, cur_len, 1'b1};
                                    end else begin
                                        n_out = '{KIND_RX_BAD, '0, r_cur, cur_len, 1'b1};
                                    end
                                    n_rx_open = 1'b0;
                                    n_cnt     = '0;
                                    n_sum     = '0;
                                    n_tmo     = '0;
                                end
                            end
                        end
                        FUNC_TICK: begin
                            if (r_rx_open) begin
                                if (r_tmo <= TMO_W'(1)) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{KIND_TIMEOUT, '0, r_cur, r_cnt, 1'b1};
                                    n_rx_open   = 1'b0;
                                    n_cnt       = '0;
                                    n_sum       = '0;
                                    n_tmo       = '0;
                                end else begin
                                    n_tmo = r_tmo - TMO_W'(1);
                                end
                            end
                        end
                        FUNC_TXWR: begin
                            o_txm.wr    = 1'b1;
                            o_txm.waddr = i_item.slot;
                            o_txm.wdata = i_item.value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pos < r_len) begin
                        n_out       = '{KIND_TX, i_txm_rdata, r_cur, r_pos, 1'b0};
                        n_tsum      = r_tsum + SUM_W'(i_txm_rdata);
                        n_pos       = pos_nx;
                        o_txm.rd    = (pos_nx < r_len);
                        o_txm.raddr = pos_nx[SLOT_W-1:0];
                    end else begin
                        n_out   = '{KIND_TX, fold_checksum(r_tsum), r_cur, r_len, 1'b1};
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_open   <= 1'b0;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_tmo       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_open   <= n_rx_open;
            r_cur       <= n_cur;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_tmo       <= n_tmo;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_pos  <= n_pos;
        r_tsum <= n_tsum;
        r_out  <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.data          = r_out.data;
    assign o_res.entry_index   = r_out.idx;
    assign o_res.byte_position = r_out.pos;
    assign o_res.last          = r_out.last;

    a_tx_no_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TX |-> !r_rx_open)
        else $error("receive frame open during transmit");

    a_tx_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TX |-> r_pos <= r_len)
        else $error("transmit position past length");

    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_txm.rd |-> !o_txm.wr)
        else $error("transmit buffer read and write in one cycle");

    a_tx_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TX && out_free && r_pos == r_len) |=>
        (r_out_valid && r_out.last && r_state == ST_IDLE))
        else $error("checksum transfer not flagged last");

endmodule

`default_nettype wire

// ===== design/lin_responder_frame_engine.sv =====
// LIN responder frame engine.
// Input channel i_item carries func/value/slot; an item is taken when valid
// and ready are both high. Output channel o_res carries kind, data,
// entry_index, byte_position and last; the final result of each item has
// last set. The table entries and inter-byte timeout sit on an APB port.
// A response byte, tick or unknown header gives its single result in the
// cycle after the transfer; a tick or transmit-buffer write that gives no
// result leaves the input ready. A publish header reads the transmit buffer
// through its single synchronous read port, one byte per cycle unless the
// output stalls; each byte is registered in the buffer, then in the output
// register; the checksum follows, and no item is taken until it is issued.
// Reset clears the frame state, the table, the transmit buffer (reads as
// zero until written) and loads a timeout of 1000 ticks.
// A stalled output holds its result in the output register; the input side
// then stops accepting until that result is transferred.
`default_nettype none

module lin_responder_frame_engine #(
    parameter int NUM_ENTRIES = lrfe_pkg::DEF_NUM_ENTRIES,
    parameter int MAX_DATA    = lrfe_pkg::DEF_MAX_DATA
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrfe_pkg::PADDR_W-1:0] paddr,
    input  logic [lrfe_pkg::PDATA_W-1:0] pwdata,
    output logic [lrfe_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    lrfe_in_if.sink                      i_item,
    lrfe_out_if.source                   o_res
);
    import lrfe_pkg::*;

    t_cfg              cfg;
    t_txm_req          txm_req;
    logic [BYTE_W-1:0] txm_rdata;

    assign pready = 1'b1;

    lrfe_cfg #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    lrfe_txmem #(
        .MAX_DATA (MAX_DATA)
    ) u_txmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (txm_req),
        .o_rdata (txm_rdata)
    );

    lrfe_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .MAX_DATA    (MAX_DATA)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (i_item),
        .o_res       (o_res),
        .o_txm       (txm_req),
        .i_txm_rdata (txm_rdata)
    );

endmodule

`default_nettype wire
